/* src/ffp_pkg.sv */
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared widths, constants and types of the flag frequency predictor.
// ----------------------------------------------------------------------------
package ffp_pkg;

  localparam int unsigned FLAG_W        = 32;
  localparam int unsigned AVG_W         = 17;
  localparam int unsigned CFG_IDX_W     = 8;
  localparam int unsigned CFG_DATA_W    = 17;
  localparam int unsigned NUM_FLAGS_DEF = 32;

  localparam logic [AVG_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [AVG_W-1:0] HALF_Q16 = 17'd32768;

  localparam logic [CFG_DATA_W-1:0] WEIGHT_RST    = 17'd6554;
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST = 17'd16384;

  localparam logic [CFG_IDX_W-1:0] REG_EMA_WEIGHT       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIDE_THRESHOLD = 8'd1;

  typedef logic [AVG_W-1:0] avg_t;

  // settings seen by every lane
  typedef struct packed {
    avg_t w;
    avg_t omw;
    avg_t thr;
    avg_t slim;
  } lane_cfg_t;

  // per request control shared by every lane
  typedef struct packed {
    logic load;
    logic restart;
  } lane_ctrl_t;

  function automatic avg_t sat_one(input logic [CFG_DATA_W-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage

/* src/ffp_in_if.sv */
// ----------------------------------------------------------------------------
// ffp_in_if
// Input channel: observed flag word and restart bit.
// ----------------------------------------------------------------------------
interface ffp_in_if
  import ffp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FLAG_W-1:0] flags;
  logic              restart;

  modport source (output valid, output flags, output restart, input ready);
  modport sink   (input valid, input flags, input restart, output ready);
endinterface

/* src/ffp_out_if.sv */
// ----------------------------------------------------------------------------
// ffp_out_if
// Result channel: strict and loose predicted flag words.
// ----------------------------------------------------------------------------
interface ffp_out_if
  import ffp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FLAG_W-1:0] strict_flags;
  logic [FLAG_W-1:0] loose_flags;

  modport source (output valid, output strict_flags, output loose_flags, input ready);
  modport sink   (input valid, input strict_flags, input loose_flags, output ready);
endinterface

/* src/ffp_cfg_if.sv */
// ----------------------------------------------------------------------------
// ffp_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ffp_cfg_if
  import ffp_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/ffp_lane.sv */
// ----------------------------------------------------------------------------
// ffp_lane
// One flag position: moving average register, blend update and decisions.
// ----------------------------------------------------------------------------
module ffp_lane
  import ffp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lane_ctrl_t ctrl,
  input  lane_cfg_t  cfg,
  input  logic       flag_bit,
  output logic       strict_hit,
  output logic       loose_hit
);

  avg_t                 avg_r;
  avg_t                 avg_nxt;
  logic [2*AVG_W-1:0]   prod;
  logic [2*AVG_W-1:0]   rnd;
  avg_t                 scaled;
  logic [AVG_W:0]       blend;

  always_comb begin
    prod   = {{AVG_W{1'b0}}, avg_r} * {{AVG_W{1'b0}}, cfg.omw};
    rnd    = prod + {{AVG_W{1'b0}}, HALF_Q16};
    scaled = rnd[AVG_W+15:16];
    blend  = {1'b0, scaled} + (flag_bit ? {1'b0, cfg.w} : {(AVG_W+1){1'b0}});
    if (ctrl.restart) begin
      avg_nxt = flag_bit ? ONE_Q16 : '0;
    end else if (blend > {1'b0, ONE_Q16}) begin
      avg_nxt = ONE_Q16;
    end else begin
      avg_nxt = blend[AVG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= HALF_Q16;
    end else if (ctrl.load) begin
      avg_r <= avg_nxt;
    end
  end

  assign strict_hit = avg_r > cfg.slim;
  assign loose_hit  = avg_r > cfg.thr;

endmodule

/* src/ffp_merge.sv */
// ----------------------------------------------------------------------------
// ffp_merge
// Gathers lane decisions into the two flag words and holds the result.
// ----------------------------------------------------------------------------
module ffp_merge
  import ffp_pkg::*;
#(
  parameter int unsigned NUM_FLAGS = NUM_FLAGS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pend_valid,
  input  logic [NUM_FLAGS-1:0] strict_hits,
  input  logic [NUM_FLAGS-1:0] loose_hits,
  output logic                 pend_adv,
  ffp_out_if.source            out_ch
);

  logic [FLAG_W-1:0] strict_word;
  logic [FLAG_W-1:0] loose_word;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [FLAG_W-1:0] strict_r;
  logic [FLAG_W-1:0] loose_r;

  for (genvar b = 0; b < FLAG_W; b++) begin : g_bit
    if (b < NUM_FLAGS) begin : g_live
      assign strict_word[b] = strict_hits[b];
      assign loose_word[b]  = loose_hits[b];
    end else begin : g_zero
      assign strict_word[b] = 1'b0;
      assign loose_word[b]  = 1'b0;
    end
  end

  assign pend_adv = pend_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    if (pend_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_adv) begin
      strict_r <= strict_word;
      loose_r  <= loose_word;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.strict_flags = strict_r;
  assign out_ch.loose_flags  = loose_r;

endmodule

/* src/flag_frequency_predictor.sv */
// ----------------------------------------------------------------------------
// flag_frequency_predictor
// Per-bit moving average of flag words with strict and loose predictions.
// ----------------------------------------------------------------------------
// request path: lane average register, then the result register in ffp_merge
// throughput: one request per cycle while the result side takes results; a stall holds input ready low
// reset: synchronous active-low; averages return to 0.5, weight to 6554,
// threshold to 16384, both channels empty
// ----------------------------------------------------------------------------
module flag_frequency_predictor
  import ffp_pkg::*;
#(
  parameter int unsigned NUM_FLAGS = NUM_FLAGS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ffp_in_if.sink    in_ch,
  ffp_out_if.source out_ch,
  ffp_cfg_if.sink   cfg_ch
);

  avg_t                 w_r, w_nxt;
  avg_t                 omw_r, omw_nxt;
  avg_t                 thr_r, thr_nxt;
  avg_t                 slim_r, slim_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic                 pend_adv;
  logic                 in_fire;
  logic                 cfg_fire;
  lane_cfg_t            lane_cfg;
  lane_ctrl_t           lane_ctrl;
  logic [NUM_FLAGS-1:0] strict_hits;
  logic [NUM_FLAGS-1:0] loose_hits;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    w_nxt    = w_r;
    omw_nxt  = omw_r;
    thr_nxt  = thr_r;
    slim_nxt = slim_r;
    if (cfg_fire) begin
      if (cfg_ch.index == REG_EMA_WEIGHT) begin
        w_nxt   = sat_one(cfg_ch.data);
        omw_nxt = ONE_Q16 - sat_one(cfg_ch.data);
      end else if (cfg_ch.index == REG_DECIDE_THRESHOLD) begin
        thr_nxt  = sat_one(cfg_ch.data);
        slim_nxt = ONE_Q16 - sat_one(cfg_ch.data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= WEIGHT_RST;
      omw_r  <= ONE_Q16 - WEIGHT_RST;
      thr_r  <= THRESHOLD_RST;
      slim_r <= ONE_Q16 - THRESHOLD_RST;
    end else begin
      w_r    <= w_nxt;
      omw_r  <= omw_nxt;
      thr_r  <= thr_nxt;
      slim_r <= slim_nxt;
    end
  end

  // pending decision waits here while the result register is held
  assign in_ch.ready = !pend_valid_r || pend_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    if (in_fire) begin
      pend_valid_nxt = 1'b1;
    end else if (pend_adv) begin
      pend_valid_nxt = 1'b0;
    end else begin
      pend_valid_nxt = pend_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
    end
  end

  assign lane_cfg.w     = w_r;
  assign lane_cfg.omw   = omw_r;
  assign lane_cfg.thr   = thr_r;
  assign lane_cfg.slim  = slim_r;
  assign lane_ctrl.load    = in_fire;
  assign lane_ctrl.restart = in_ch.restart;

  for (genvar i = 0; i < NUM_FLAGS; i++) begin : g_lane
    logic flag_bit;
    if (i < FLAG_W) begin : g_obs
      assign flag_bit = in_ch.flags[i];
    end else begin : g_clear
      assign flag_bit = 1'b0;
    end
    ffp_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (lane_ctrl),
      .cfg        (lane_cfg),
      .flag_bit   (flag_bit),
      .strict_hit (strict_hits[i]),
      .loose_hit  (loose_hits[i])
    );
  end

  ffp_merge #(
    .NUM_FLAGS (NUM_FLAGS)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .pend_valid  (pend_valid_r),
    .strict_hits (strict_hits),
    .loose_hits  (loose_hits),
    .pend_adv    (pend_adv),
    .out_ch      (out_ch)
  );

`ifndef ASSERT_OFF
  a_fire_pends: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pend_valid_r)
    else $error("accepted request left no pending decision");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !pend_valid_r |-> in_ch.ready)
    else $error("input not ready with empty pipeline");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_valid_r && out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while pending decision is stalled");

  a_weight_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_fire && cfg_ch.index == REG_EMA_WEIGHT) |=>
      ({1'b0, w_r} + {1'b0, omw_r} == {1'b0, ONE_Q16}))
    else $error("weight and its complement disagree");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Flag frequency predictor: a per-bit moving average model runs beside the
// block, tracks each register write, and checks both predicted words of
// every result. Directed tests cover the default settings, restarts and
// extreme register values. Random traffic then runs in bursts with gaps
// through several settings, with the result side stalled at random and once
// held off long enough to fill the block.
// ----------------------------------------------------------------------------
module testbench;
  import ffp_pkg::*;

  localparam int LANES        = 32;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [FLAG_W-1:0] strict_w;
    logic [FLAG_W-1:0] loose_w;
  } flag_pair_t;

  logic clk = 1'b0;
  logic rst_n;

  ffp_in_if  in_bus ();
  ffp_out_if out_bus ();
  ffp_cfg_if cfg_bus ();

  flag_frequency_predictor #(
    .NUM_FLAGS(LANES)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  avg_t              lane_avg [LANES];
  avg_t              cur_weight;
  avg_t              cur_threshold;
  flag_pair_t        expected_words [$];
  int                errors    = 0;
  int                cycles    = 0;
  int                stall_mode = 0;
  int                hold_asks = 0;
  logic [FLAG_W-1:0] habit_word;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // moving average update of every lane, then both threshold decisions
  task automatic blend_flags(input logic [FLAG_W-1:0] flags, input logic restart,
                             output flag_pair_t pair);
    avg_t        w;
    avg_t        thr;
    avg_t        slim;
    logic [34:0] prod;
    logic [17:0] nxt;
    w    = (cur_weight > ONE_Q16) ? ONE_Q16 : cur_weight;
    thr  = (cur_threshold > ONE_Q16) ? ONE_Q16 : cur_threshold;
    slim = ONE_Q16 - thr;
    pair = '0;
    for (int i = 0; i < LANES; i++) begin
      if (restart) begin
        lane_avg[i] = flags[i] ? ONE_Q16 : '0;
      end else begin
        prod = 35'(lane_avg[i]) * 35'(ONE_Q16 - w) + 35'(HALF_Q16);
        nxt  = 18'(prod >> 16) + (flags[i] ? 18'(w) : 18'd0);
        lane_avg[i] = (nxt > 18'(ONE_Q16)) ? ONE_Q16 : avg_t'(nxt);
      end
      pair.strict_w[i] = lane_avg[i] > slim;
      pair.loose_w[i]  = lane_avg[i] > thr;
    end
  endtask

  always @(posedge clk) begin : monitor
    flag_pair_t want;
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) lane_avg[i] = HALF_Q16;
      cur_weight    = WEIGHT_RST;
      cur_threshold = THRESHOLD_RST;
      expected_words.delete();
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        if (cfg_bus.index == REG_EMA_WEIGHT) cur_weight = cfg_bus.data;
        else if (cfg_bus.index == REG_DECIDE_THRESHOLD) cur_threshold = cfg_bus.data;
      end
      if (in_bus.valid && in_bus.ready) begin
        blend_flags(in_bus.flags, in_bus.restart, want);
        expected_words.push_back(want);
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result, got strict %h loose %h", $time,
                   out_bus.strict_flags, out_bus.loose_flags);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (out_bus.strict_flags !== want.strict_w) begin
            $display("%0t: strict_flags mismatch, expected %h, got %h", $time,
                     want.strict_w, out_bus.strict_flags);
            errors++;
          end
          if (out_bus.loose_flags !== want.loose_w) begin
            $display("%0t: loose_flags mismatch, expected %h, got %h", $time,
                     want.loose_w, out_bus.loose_flags);
            errors++;
          end
        end
      end
    end
  end

  // result side: random stall pattern, or a long hold-off when asked
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= ($urandom_range(0, 3) != 0);
          default: out_bus.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  task automatic send_flags(input logic [FLAG_W-1:0] flags, input logic restart);
    in_bus.valid   <= 1'b1;
    in_bus.flags   <= flags;
    in_bus.restart <= restart;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic idle_input(input int n);
    if (n > 0) begin
      in_bus.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly a recurring word with sparse noise, so averages settle and cross
  task automatic pick_flags(output logic [FLAG_W-1:0] flags, output logic restart);
    int r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) habit_word = $urandom;
    if (r < 60) flags = habit_word ^ ($urandom & $urandom & $urandom);
    else if (r < 80) flags = $urandom;
    else if (r < 88) flags = '0;
    else if (r < 94) flags = ~habit_word;
    else flags = '1;
    restart = ($urandom_range(0, 99) < 4);
  endtask

  task automatic test_default_blend;
    stall_mode = 0;
    send_flags('0, 1'b0);
    send_flags('1, 1'b0);
    send_flags(32'hAAAA_AAAA, 1'b0);
    send_flags(32'h5555_5555, 1'b0);
    send_flags('1, 1'b0);
    send_flags('1, 1'b0);
    send_flags(32'h8000_0001, 1'b0);
    send_flags('0, 1'b0);
    drain();
  endtask

  task automatic test_restart;
    stall_mode = 1;
    send_flags('1, 1'b1);
    send_flags('0, 1'b0);
    send_flags(32'hA5A5_5A5A, 1'b1);
    send_flags('0, 1'b1);
    send_flags(32'hFFFF_0000, 1'b0);
    drain();
  endtask

  task automatic test_register_extremes;
    logic [CFG_DATA_W-1:0] weights [5]    = '{17'd0, 17'd65536, 17'h1FFFF, 17'd1, 17'd65535};
    logic [CFG_DATA_W-1:0] thresholds [5] = '{17'd0, 17'd65536, 17'h1FFFF, 17'd32768, 17'd65535};
    stall_mode = 0;
    for (int k = 0; k < 5; k++) begin
      write_reg(REG_EMA_WEIGHT, weights[k]);
      write_reg(REG_DECIDE_THRESHOLD, thresholds[k]);
      write_reg(k[0] ? 8'hFF : 8'd2, 17'h1FFFF);
      send_flags(32'hF0F0_0F0F, 1'b0);
      send_flags(32'h0FF0_F00F, k == 2);
      drain();
    end
  endtask

  task automatic test_random_traffic;
    logic [FLAG_W-1:0] flags;
    logic              restart;
    int unsigned       w;
    int unsigned       thr;
    int                sent;
    int                burst;
    habit_word = $urandom;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin w = $urandom_range(2000, 20000); thr = $urandom_range(0, 32768); end
        1: begin w = 65536; thr = 0; end
        2: begin w = 0; thr = 65536; end
        3: begin w = $urandom_range(65537, 131071); thr = $urandom_range(65537, 131071); end
        4: begin w = $urandom_range(0, 131071); thr = $urandom_range(0, 131071); end
        5: begin w = $urandom_range(500, 12000); thr = $urandom_range(20000, 45000); end
        default: begin w = $urandom_range(0, 65535); thr = $urandom_range(0, 65535); end
      endcase
      write_reg(REG_EMA_WEIGHT, CFG_DATA_W'(w));
      write_reg(REG_DECIDE_THRESHOLD, CFG_DATA_W'(thr));
      if ($urandom_range(0, 1))
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
      stall_mode = phase % 3;
      sent = 0;
      while (sent < 100) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && sent < 100; b++) begin
          pick_flags(flags, restart);
          send_flags(flags, restart);
          sent++;
        end
        idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end
      drain();
    end
  endtask

  task automatic test_backpressure;
    logic [FLAG_W-1:0] flags;
    logic              restart;
    write_reg(REG_EMA_WEIGHT, 17'd8192);
    write_reg(REG_DECIDE_THRESHOLD, 17'd24000);
    stall_mode = 0;
    hold_asks++;
    for (int n = 0; n < 48; n++) begin
      pick_flags(flags, restart);
      send_flags(flags, restart);
    end
    drain();
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.flags   <= '0;
    in_bus.restart <= 1'b0;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= '0;
    cfg_bus.data   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_default_blend();
    test_restart();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();

    drain();
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
src/ffp_pkg.sv
src/ffp_in_if.sv
src/ffp_out_if.sv
src/ffp_cfg_if.sv
src/ffp_lane.sv
src/ffp_merge.sv
src/flag_frequency_predictor.sv
sim/testbench.sv
